// File: src/qari_pkg.sv
// shared constants for the quad area-ratio invariant block
package qari_pkg;
  localparam int unsigned MinAreaW   = 50;
  localparam logic [MinAreaW-1:0] MinAreaRst = MinAreaW'(65536);
  localparam int unsigned VertW      = 2;
  localparam int unsigned NumTri     = 4;
  localparam int unsigned FrontStgs  = 5;
  typedef logic [VertW-1:0] vert_t;
endpackage

// File: src/quad_area_ratio_invariant.sv
// quad area-ratio invariant: one quad per cycle through a fixed-depth pipeline.
// Each quad is a single beat of eight signed coordinates. It runs through five
// front stages: coordinate differences, products, absolute cross terms, pairwise
// compares, and ordering with the threshold test. After those come
// RATIO_FRAC_BITS+1 restoring division stages that form both ratios at once.
// A new quad is taken every cycle while the output side takes beats; the whole
// pipeline holds when the output register is full and not taken. min_area is
// loaded through cfg_we_i and cfg_wdata_i; the user must load it only while the
// pipeline is empty, and the block itself does not enforce this.
module quad_area_ratio_invariant import qari_pkg::*; #(
  parameter int unsigned COORD_BITS      = 24,
  parameter int unsigned RATIO_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [MinAreaW-1:0]        cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [COORD_BITS-1:0] px0_i,
  input  logic signed [COORD_BITS-1:0] py0_i,
  input  logic signed [COORD_BITS-1:0] px1_i,
  input  logic signed [COORD_BITS-1:0] py1_i,
  input  logic signed [COORD_BITS-1:0] px2_i,
  input  logic signed [COORD_BITS-1:0] py2_i,
  input  logic signed [COORD_BITS-1:0] px3_i,
  input  logic signed [COORD_BITS-1:0] py3_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       skip_o,
  output logic [RATIO_FRAC_BITS:0]   ratio_second_o,
  output logic [RATIO_FRAC_BITS:0]   ratio_third_o,
  output logic [VertW-1:0]           rank0_vertex_o,
  output logic [VertW-1:0]           rank1_vertex_o,
  output logic [VertW-1:0]           rank2_vertex_o,
  output logic [VertW-1:0]           rank3_vertex_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned AW = PW;
  localparam int unsigned RW = AW + 1;
  localparam int unsigned ND = RATIO_FRAC_BITS + 1;
  localparam int unsigned NS = FrontStgs + ND;

  logic [MinAreaW-1:0] min_area_q;
  logic [NS-1:0]       vld_q;
  logic                en;

  assign en          = ~vld_q[NS-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q <= MinAreaRst;
    end else if (cfg_we_i) begin
      min_area_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] dif_d [NumTri][4];
  logic signed [DW-1:0] dif_q [NumTri][4];
  logic signed [DW-1:0] x0, y0, x1, y1, x2, y2, x3, y3;

  always_comb begin
    x0 = DW'(px0_i); y0 = DW'(py0_i);
    x1 = DW'(px1_i); y1 = DW'(py1_i);
    x2 = DW'(px2_i); y2 = DW'(py2_i);
    x3 = DW'(px3_i); y3 = DW'(py3_i);
    dif_d[0][0] = x0 - x1; dif_d[0][1] = y1 - y2; dif_d[0][2] = x1 - x2; dif_d[0][3] = y0 - y1;
    dif_d[1][0] = x0 - x1; dif_d[1][1] = y1 - y3; dif_d[1][2] = x1 - x3; dif_d[1][3] = y0 - y1;
    dif_d[2][0] = x0 - x3; dif_d[2][1] = y3 - y2; dif_d[2][2] = x3 - x2; dif_d[2][3] = y0 - y3;
    dif_d[3][0] = x3 - x1; dif_d[3][1] = y1 - y2; dif_d[3][2] = x1 - x2; dif_d[3][3] = y3 - y1;
  end

  // stage 2: products
  logic signed [PW-1:0] prod_q [NumTri][2];
  // stage 3: absolute cross terms
  logic [AW-1:0]        area3_q [NumTri];
  logic signed [PW:0]   crs [NumTri];
  logic [PW:0]          crs_abs [NumTri];
  // stage 4: pairwise compares
  logic [AW-1:0]        area4_q [NumTri];
  logic                 gt_q [NumTri][NumTri];
  // stage 5: ordering
  logic [AW-1:0]        srt [NumTri];
  vert_t                svt [NumTri];
  logic [VertW-1:0]     rnk [NumTri];
  logic                 skip_d;

  always_comb begin
    for (int i = 0; i < NumTri; i++) begin
      crs[i]     = (PW+1)'(prod_q[i][0]) - (PW+1)'(prod_q[i][1]);
      crs_abs[i] = crs[i][PW] ? (PW+1)'(-crs[i]) : (PW+1)'(crs[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < NumTri; i++) begin
      rnk[i] = '0;
      for (int j = 0; j < NumTri; j++) begin
        if (j < i && !gt_q[i][j]) rnk[i] = rnk[i] + VertW'(1);
        if (j > i && gt_q[j][i])  rnk[i] = rnk[i] + VertW'(1);
      end
    end
    for (int k = 0; k < NumTri; k++) begin
      srt[k] = '0;
      svt[k] = '0;
      for (int i = 0; i < NumTri; i++) begin
        if (rnk[i] == VertW'(k)) begin
          srt[k] = area4_q[i];
          svt[k] = VertW'(NumTri - 1 - i);
        end
      end
    end
    skip_d = ((AW > MinAreaW ? AW : MinAreaW)'(srt[NumTri-1])
              < (AW > MinAreaW ? AW : MinAreaW)'(min_area_q)) || (srt[0] == '0);
  end

  // division stages
  logic [AW-1:0] den_q  [ND+1];
  logic [RW-1:0] r2_q   [ND+1];
  logic [RW-1:0] r3_q   [ND+1];
  logic [ND-1:0] q2_q   [ND+1];
  logic [ND-1:0] q3_q   [ND+1];
  logic          skp_q  [ND+1];
  vert_t         vt_q   [ND+1][NumTri];
  logic [RW-1:0] r2n [ND];
  logic [RW-1:0] r3n [ND];
  logic          ge2 [ND];
  logic          ge3 [ND];

  always_comb begin
    for (int k = 0; k < ND; k++) begin
      ge2[k] = r2_q[k] >= RW'(den_q[k]);
      ge3[k] = r3_q[k] >= RW'(den_q[k]);
      r2n[k] = ge2[k] ? r2_q[k] - RW'(den_q[k]) : r2_q[k];
      r3n[k] = ge3[k] ? r3_q[k] - RW'(den_q[k]) : r3_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dif_q <= dif_d;
      for (int i = 0; i < NumTri; i++) begin
        prod_q[i][0] <= dif_q[i][0] * dif_q[i][1];
        prod_q[i][1] <= dif_q[i][2] * dif_q[i][3];
        area3_q[i]   <= AW'(crs_abs[i]);
        area4_q[i]   <= area3_q[i];
        for (int j = 0; j < NumTri; j++) begin
          gt_q[i][j] <= area3_q[i] > area3_q[j];
        end
      end
      den_q[0] <= srt[0];
      r2_q[0]  <= RW'(srt[1]);
      r3_q[0]  <= RW'(srt[2]);
      q2_q[0]  <= '0;
      q3_q[0]  <= '0;
      skp_q[0] <= skip_d;
      vt_q[0]  <= svt;
      for (int k = 0; k < ND; k++) begin
        den_q[k+1] <= den_q[k];
        r2_q[k+1]  <= {r2n[k][RW-2:0], 1'b0};
        r3_q[k+1]  <= {r3n[k][RW-2:0], 1'b0};
        q2_q[k+1]  <= {q2_q[k][ND-2:0], ge2[k]};
        q3_q[k+1]  <= {q3_q[k][ND-2:0], ge3[k]};
        skp_q[k+1] <= skp_q[k];
        vt_q[k+1]  <= vt_q[k];
      end
    end
  end

  assign skip_o         = skp_q[ND];
  assign ratio_second_o = skp_q[ND] ? '0 : q2_q[ND];
  assign ratio_third_o  = skp_q[ND] ? '0 : q3_q[ND];
  assign rank0_vertex_o = skp_q[ND] ? '0 : vt_q[ND][0];
  assign rank1_vertex_o = skp_q[ND] ? '0 : vt_q[ND][1];
  assign rank2_vertex_o = skp_q[ND] ? '0 : vt_q[ND][2];
  assign rank3_vertex_o = skp_q[ND] ? '0 : vt_q[ND][3];

endmodule
